// ----- hw/rtl/kc_pkg.sv -----
package kc_pkg;

	localparam int NUM_SLOTS   = 8;
	localparam int RESULT_CAP  = 8;

	localparam int FD_W    = 16;
	localparam int TIME_W  = 48;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	localparam int CNT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int NF_W  = $clog2(RESULT_CAP + 1);

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_CHECK  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RC_OK        = 3'd0,
		RC_FULL      = 3'd1,
		RC_NOT_FOUND = 3'd2,
		RC_PING      = 3'd3,
		RC_DEAD      = 3'd4,
		RC_NONE_DUE  = 3'd5
	} rc_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PING_AFTER = 1'd0,
		REG_DEAD_AFTER = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic              used;
		logic [FD_W-1:0]   fd;
		logic [TIME_W-1:0] seen;
	} slot_t;

endpackage

// ----- hw/rtl/kc_in_if.sv -----
interface kc_in_if;
	import kc_pkg::*;

	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [FD_W-1:0]   client_fd;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output kind, output client_fd, output now_ms, input ready);
	modport sink   (input valid, input kind, input client_fd, input now_ms, output ready);
endinterface

// ----- hw/rtl/kc_out_if.sv -----
interface kc_out_if;
	import kc_pkg::*;

	logic            valid;
	logic            ready;
	rc_t             result_code;
	logic [FD_W-1:0] client_fd_out;
	logic            last;

	modport source (output valid, output result_code, output client_fd_out, output last,
		input ready);
	modport sink   (input valid, input result_code, input client_fd_out, input last,
		output ready);
endinterface

// ----- hw/rtl/kc_cell.sv -----
module kc_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  kc_pkg::slot_t d,
	output kc_pkg::slot_t q
);
	import kc_pkg::*;

	logic              used_q;
	logic [FD_W-1:0]   fd_q;
	logic [TIME_W-1:0] seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (shift) begin
			used_q <= d.used;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			fd_q   <= d.fd;
			seen_q <= d.seen;
		end
	end

	assign q = '{used: used_q, fd: fd_q, seen: seen_q};
endmodule

// ----- hw/rtl/kc_ctrl.sv -----
module kc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	kc_in_if.sink                  evt,
	kc_out_if.source               res,
	input  logic [kc_pkg::CFG_W-1:0] ping_after,
	input  logic [kc_pkg::CFG_W-1:0] dead_after,
	input  kc_pkg::slot_t          head,
	output kc_pkg::slot_t          feedback,
	output logic                   shift
);
	import kc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic              pend_v_q;
	logic [NF_W-1:0]   nfound_q;
	kind_t             kind_q;
	logic [FD_W-1:0]   fd_q;
	logic [TIME_W-1:0] now_q;
	rc_t               pend_code_q;
	logic [FD_W-1:0]   pend_fd_q;

	logic              out_valid_q;
	rc_t               out_code_q;
	logic [FD_W-1:0]   out_fd_q;
	logic              out_last_q;

	slot_t           fb;
	logic            hit;
	logic [TIME_W:0] sum_ping;
	logic [TIME_W:0] sum_dead;
	logic [TIME_W:0] now_ext;
	logic            due;
	logic            dead;
	logic            need_emit;
	logic            can_push;
	logic            step;
	logic            final_push;
	logic            accept;
	rc_t             final_code;
	logic [FD_W-1:0] final_fd;

	assign now_ext  = {1'b0, now_q};
	assign sum_ping = {1'b0, head.seen} + (TIME_W+1)'(ping_after);
	assign sum_dead = {1'b0, head.seen} + (TIME_W+1)'(dead_after);

	// head slot update for add, remove and update
	always_comb begin
		fb  = head;
		hit = 1'b0;
		case (kind_q)
			KIND_ADD: begin
				if (!done_q && !head.used) begin
					fb.used = 1'b1;
					fb.fd   = fd_q;
					fb.seen = now_q;
					hit     = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (!done_q && head.used && head.fd == fd_q) begin
					fb.used = 1'b0;
					hit     = 1'b1;
				end
			end
			KIND_UPDATE: begin
				if (!done_q && head.used && head.fd == fd_q) begin
					fb.seen = now_q;
					hit     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign due  = (kind_q == KIND_CHECK) && head.used && (sum_ping <= now_ext)
		&& (nfound_q < NF_W'(RESULT_CAP));
	assign dead = sum_dead <= now_ext;

	assign need_emit  = due && pend_v_q;
	assign can_push   = !out_valid_q || res.ready;
	assign step       = (state_q == ST_SCAN) && (!need_emit || can_push);
	assign final_push = (state_q == ST_FINAL) && can_push;
	assign accept     = evt.valid && evt.ready;

	assign evt.ready = (state_q == ST_IDLE);
	assign shift     = step;
	assign feedback  = fb;

	always_comb begin
		final_code = RC_OK;
		final_fd   = '0;
		case (kind_q)
			KIND_ADD:    final_code = done_q ? RC_OK : RC_FULL;
			KIND_REMOVE: final_code = done_q ? RC_OK : RC_NOT_FOUND;
			KIND_UPDATE: final_code = done_q ? RC_OK : RC_NOT_FOUND;
			KIND_CHECK: begin
				if (pend_v_q) begin
					final_code = pend_code_q;
					final_fd   = pend_fd_q;
				end else begin
					final_code = RC_NONE_DUE;
				end
			end
			default: final_code = RC_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			pend_v_q <= 1'b0;
			nfound_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q  <= ST_SCAN;
						cnt_q    <= '0;
						done_q   <= 1'b0;
						pend_v_q <= 1'b0;
						nfound_q <= '0;
					end
				end
				ST_SCAN: begin
					if (step) begin
						if (hit) begin
							done_q <= 1'b1;
						end
						if (due) begin
							pend_v_q <= 1'b1;
							nfound_q <= nfound_q + NF_W'(1);
						end
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == CNT_W'(NUM_SLOTS - 1)) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					if (final_push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= evt.kind;
			fd_q   <= evt.client_fd;
			now_q  <= evt.now_ms;
		end
		if (step && due) begin
			pend_code_q <= dead ? RC_DEAD : RC_PING;
			pend_fd_q   <= head.fd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((step && need_emit) || final_push) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && need_emit) begin
			out_code_q <= pend_code_q;
			out_fd_q   <= pend_fd_q;
			out_last_q <= 1'b0;
		end else if (final_push) begin
			out_code_q <= final_code;
			out_fd_q   <= final_fd;
			out_last_q <= 1'b1;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.result_code   = out_code_q;
	assign res.client_fd_out = out_fd_q;
	assign res.last          = out_last_q;
endmodule

// ----- hw/rtl/client_keepalive_table.sv -----
// client keep-alive table
//
// evt channel: one item per connection event (add, remove, activity update,
// liveness check). res channel: result items; the final item of an event
// carries last. add, remove and update give one status item; a check gives
// one item per due slot in slot order (at most eight), or one nothing-due item.
// config port: cfg_we/cfg_idx/cfg_wdata set the ping and dead periods; write
// only while no event is in flight.
//
// the slots sit in a ring of cells that rotates once per cycle during an
// event unless the res channel stalls it; the head cell is examined and
// rewritten as it passes the controller. an event goes from acceptance
// through one ring rotation per slot to a final step that posts the final
// item in the output register; no new event is accepted until that item
// is posted. a stalled res channel freezes the ring whenever a further
// item must be posted, so no item is lost; the last item waits in the
// output register while the next event is taken.
// reset clears all used flags and loads the default periods (5000, 10000).
module client_keepalive_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [kc_pkg::CFG_W-1:0]       cfg_wdata,
	kc_in_if.sink                          evt,
	kc_out_if.source                       res
);
	import kc_pkg::*;

	logic [CFG_W-1:0] ping_after_q;
	logic [CFG_W-1:0] dead_after_q;

	// ring of slot cells, cell 0 is the head
	slot_t cell_d [NUM_SLOTS];
	slot_t cell_q [NUM_SLOTS];
	slot_t feedback;
	logic  shift;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_after_q <= CFG_W'(5000);
			dead_after_q <= CFG_W'(10000);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PING_AFTER: ping_after_q <= cfg_wdata;
				REG_DEAD_AFTER: dead_after_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		// tail cell takes the rewritten head, the rest take their upper neighbor
		if (i == NUM_SLOTS - 1) begin : g_tail
			assign cell_d[i] = feedback;
		end else begin : g_mid
			assign cell_d[i] = cell_q[i+1];
		end

		kc_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.d     (cell_d[i]),
			.q     (cell_q[i])
		);
	end

	kc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.res       (res),
		.ping_after(ping_after_q),
		.dead_after(dead_after_q),
		.head      (cell_q[0]),
		.feedback  (feedback),
		.shift     (shift)
	);

`ifndef SYNTH
	// one event at a time: no new item right after one is taken
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready |=> !evt.ready)
		else $error("event accepted while previous one in flight");

	// ring only moves while an event is in progress
	a_ring_busy: assert property (@(posedge clk) disable iff (!arst_n)
		shift |-> !evt.ready)
		else $error("ring rotated while idle");

	// status and nothing-due items are always the final item of an event
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.result_code == RC_OK || res.result_code == RC_FULL
		|| res.result_code == RC_NOT_FOUND || res.result_code == RC_NONE_DUE)
		|-> res.last)
		else $error("status item without last");
`endif
endmodule
